[rtl/core/mrps_pkg.sv]
// Shared types, widths, register codes and reset values for the
// mean-reverting path block. No dependencies.
`timescale 1ns / 1ps

package mrps_pkg;

  // Datapath widths
  localparam int PRICE_W = 32;
  localparam int STEP_W  = 20;
  localparam int GAIN_W  = 32;
  localparam int NOISE_W = PRICE_W - 1;
  localparam int FRAC_W  = 16;

  // Growth headroom for price + reversion term +/- noise
  localparam int SUM_W = PRICE_W + 3;

  // Configuration port geometry
  localparam int CFG_DATA_W   = (PRICE_W > 32) ? 64 : 32;
  localparam int CFG_ADDR_LSB = (CFG_DATA_W == 64) ? 3 : 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_ADDR_W   = CFG_ADDR_LSB + CFG_IDX_W;

  typedef logic signed [PRICE_W-1:0] price_t;
  typedef logic        [STEP_W-1:0]  step_t;
  typedef logic        [GAIN_W-1:0]  gain_t;
  typedef logic        [NOISE_W-1:0] noise_t;

  // Register map, in address order
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN,
    REG_MEAN,
    REG_NOISE,
    REG_START,
    REG_UPPER,
    REG_LOWER,
    REG_LENGTH
  } reg_idx_t;

  // Saturation limits
  localparam price_t PRICE_MAX = price_t'({1'b0, {(PRICE_W-1){1'b1}}});
  localparam price_t PRICE_MIN = price_t'(~PRICE_MAX);

  // Register reset values (prices in fixed point, FRAC_W fraction bits)
  localparam gain_t  GAIN_RST   = gain_t'(429497);
  localparam price_t MEAN_RST   = price_t'(100 << FRAC_W);
  localparam noise_t NOISE_RST  = noise_t'(6554);
  localparam price_t START_RST  = price_t'(100 << FRAC_W);
  localparam price_t UPPER_RST  = price_t'(110 << FRAC_W);
  localparam price_t LOWER_RST  = price_t'(90 << FRAC_W);
  localparam step_t  LENGTH_RST = step_t'(1000000);

  // Current register contents
  typedef struct packed {
    gain_t  gain;
    price_t mean;
    noise_t noise;
    price_t start;
    price_t upper;
    price_t lower;
    step_t  length;
  } cfg_t;

  // Price stage to statistics stage
  typedef struct packed {
    price_t price;
    step_t  step;
    logic   path_begin;
    logic   done;
  } step_res_t;

  // Statistics stage result
  typedef struct packed {
    price_t price;
    step_t  step;
    price_t max_price;
    step_t  max_step;
    price_t min_price;
    step_t  min_step;
    step_t  crossings;
    logic   done;
  } stats_res_t;

endpackage

[rtl/core/mrps_if.sv]
// Valid/ready channel interfaces for the step input and the result output.
// Depends on mrps_pkg.
`timescale 1ns / 1ps

interface mrps_in_if;
  logic valid;
  logic ready;
  logic up_step;
  logic restart_path;

  modport source (output valid, output up_step, output restart_path, input ready);
  modport sink   (input valid, input up_step, input restart_path, output ready);
endinterface

interface mrps_out_if;
  logic                  valid;
  logic                  ready;
  mrps_pkg::price_t      price;
  mrps_pkg::step_t       step_number;
  mrps_pkg::price_t      max_price;
  mrps_pkg::step_t       max_step;
  mrps_pkg::price_t      min_price;
  mrps_pkg::step_t       min_step;
  mrps_pkg::step_t       crossing_count;
  logic                  path_done;

  modport source (
    output valid, output price, output step_number, output max_price, output max_step,
    output min_price, output min_step, output crossing_count, output path_done,
    input ready
  );
  modport sink (
    input valid, input price, input step_number, input max_price, input max_step,
    input min_price, input min_step, input crossing_count, input path_done,
    output ready
  );
endinterface

[rtl/core/mean_reverting_path_with_stats_core.sv]
// Top level of the mean-reverting path generator with running statistics.
// Depends on mrps_pkg, mrps_if, mrps_cfg, mrps_price and mrps_stats.
//
//   Channel   Port group      Direction  Moves
//   --------  --------------  ---------  ------------------------------------
//   input     in_ch           sink       up_step, restart_path
//   result    out_ch          source     price, step and path statistics
//   config    psel..pready    slave      APB-style register writes and reads
//
// One transaction per cycle sustained while results are taken; a result is
// registered in the price stage, then in the statistics stage. The rate is set
// by the price recurrence: the multiply-add-saturate loop closes through the
// price register. Reset is synchronous, active low; the input is ready right
// after reset. A stalled result holds in the output register while one more
// input transaction is taken into the price stage.
`timescale 1ns / 1ps

module mean_reverting_path_with_stats_core (
  input  logic                            clk,
  input  logic                            rst_n,
  mrps_in_if.sink                         in_ch,
  mrps_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mrps_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mrps_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mrps_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  mrps_pkg::cfg_t       cfg;
  mrps_pkg::step_res_t  step_res;
  mrps_pkg::stats_res_t stats_res;

  logic s1_valid_r, s1_valid_nxt, s2_valid_r, s2_valid_nxt;
  logic in_acc, s2_adv;

  assign pready = 1'b1;

  // Pipeline flow control
  assign s2_adv      = s1_valid_r && (!s2_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s2_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = in_acc || (s1_valid_r && !s2_adv);
    s2_valid_nxt = s2_adv || (s2_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  mrps_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  mrps_price u_price (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (in_acc),
    .up_step      (in_ch.up_step),
    .restart_path (in_ch.restart_path),
    .cfg          (cfg),
    .res          (step_res)
  );

  mrps_stats u_stats (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (s2_adv),
    .step_in (step_res),
    .cfg     (cfg),
    .res     (stats_res)
  );

  // Result channel
  assign out_ch.valid          = s2_valid_r;
  assign out_ch.price          = stats_res.price;
  assign out_ch.step_number    = stats_res.step;
  assign out_ch.max_price      = stats_res.max_price;
  assign out_ch.max_step       = stats_res.max_step;
  assign out_ch.min_price      = stats_res.min_price;
  assign out_ch.min_step       = stats_res.min_step;
  assign out_ch.crossing_count = stats_res.crossings;
  assign out_ch.path_done      = stats_res.done;

endmodule

[rtl/core/mrps_cfg.sv]
// APB-style configuration register file for the path generator.
// Depends on mrps_pkg.
`timescale 1ns / 1ps

module mrps_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mrps_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mrps_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mrps_pkg::CFG_DATA_W-1:0] prdata,
  output mrps_pkg::cfg_t                  cfg
);

  mrps_pkg::cfg_t     cfg_r;
  mrps_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx   = mrps_pkg::reg_idx_t'(paddr[mrps_pkg::CFG_ADDR_W-1:mrps_pkg::CFG_ADDR_LSB]);
  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  // Register writes in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain   <= mrps_pkg::GAIN_RST;
      cfg_r.mean   <= mrps_pkg::MEAN_RST;
      cfg_r.noise  <= mrps_pkg::NOISE_RST;
      cfg_r.start  <= mrps_pkg::START_RST;
      cfg_r.upper  <= mrps_pkg::UPPER_RST;
      cfg_r.lower  <= mrps_pkg::LOWER_RST;
      cfg_r.length <= mrps_pkg::LENGTH_RST;
    end else if (wr_en) begin
      case (idx)
        mrps_pkg::REG_GAIN:   cfg_r.gain   <= pwdata[mrps_pkg::GAIN_W-1:0];
        mrps_pkg::REG_MEAN:   cfg_r.mean   <= pwdata[mrps_pkg::PRICE_W-1:0];
        mrps_pkg::REG_NOISE:  cfg_r.noise  <= pwdata[mrps_pkg::NOISE_W-1:0];
        mrps_pkg::REG_START:  cfg_r.start  <= pwdata[mrps_pkg::PRICE_W-1:0];
        mrps_pkg::REG_UPPER:  cfg_r.upper  <= pwdata[mrps_pkg::PRICE_W-1:0];
        mrps_pkg::REG_LOWER:  cfg_r.lower  <= pwdata[mrps_pkg::PRICE_W-1:0];
        mrps_pkg::REG_LENGTH: cfg_r.length <= pwdata[mrps_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux, zero extended
  always_comb begin
    case (idx)
      mrps_pkg::REG_GAIN:   prdata = mrps_pkg::CFG_DATA_W'(cfg_r.gain);
      mrps_pkg::REG_MEAN:   prdata = mrps_pkg::CFG_DATA_W'($unsigned(cfg_r.mean));
      mrps_pkg::REG_NOISE:  prdata = mrps_pkg::CFG_DATA_W'(cfg_r.noise);
      mrps_pkg::REG_START:  prdata = mrps_pkg::CFG_DATA_W'($unsigned(cfg_r.start));
      mrps_pkg::REG_UPPER:  prdata = mrps_pkg::CFG_DATA_W'($unsigned(cfg_r.upper));
      mrps_pkg::REG_LOWER:  prdata = mrps_pkg::CFG_DATA_W'($unsigned(cfg_r.lower));
      mrps_pkg::REG_LENGTH: prdata = mrps_pkg::CFG_DATA_W'(cfg_r.length);
      default:              prdata = '0;
    endcase
  end

endmodule

[rtl/core/mrps_price.sv]
// Price stage: one Euler step of the mean-reverting price per transaction,
// plus the step counter and path start/end logic. Depends on mrps_pkg.
`timescale 1ns / 1ps

module mrps_price (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic                up_step,
  input  logic                restart_path,
  input  mrps_pkg::cfg_t      cfg,
  output mrps_pkg::step_res_t res
);

  localparam int DIFF_W = mrps_pkg::PRICE_W + 1;
  localparam int PROD_W = DIFF_W + mrps_pkg::GAIN_W + 1;

  mrps_pkg::price_t price_r, price_nxt, base_price;
  mrps_pkg::step_t  cnt_r, cnt_nxt, len;
  logic             begin_r, begin_nxt, done_r, done_nxt;

  logic signed [DIFF_W-1:0]          diff;
  logic signed [PROD_W-1:0]          prod;
  logic signed [DIFF_W-1:0]          term;
  logic signed [mrps_pkg::SUM_W-1:0] sum;

  // Path start test and counter
  always_comb begin
    len        = (cfg.length == '0) ? mrps_pkg::step_t'(1) : cfg.length;
    begin_nxt  = restart_path || (cnt_r >= len);
    base_price = begin_nxt ? cfg.start : price_r;
    cnt_nxt    = begin_nxt ? mrps_pkg::step_t'(1) : cnt_r + mrps_pkg::step_t'(1);
    done_nxt   = (cnt_nxt >= len);
  end

  // Reversion term, floored by the arithmetic shift, then noise and saturation
  always_comb begin
    diff = DIFF_W'(cfg.mean) - DIFF_W'(base_price);
    prod = PROD_W'(diff) * $signed(PROD_W'(cfg.gain));
    term = prod[mrps_pkg::GAIN_W +: DIFF_W];
    sum  = mrps_pkg::SUM_W'(base_price) + mrps_pkg::SUM_W'(term);
    if (up_step) begin
      sum = sum + $signed(mrps_pkg::SUM_W'(cfg.noise));
    end else begin
      sum = sum - $signed(mrps_pkg::SUM_W'(cfg.noise));
    end
    priority if (sum > mrps_pkg::SUM_W'(mrps_pkg::PRICE_MAX)) begin
      price_nxt = mrps_pkg::PRICE_MAX;
    end else if (sum < mrps_pkg::SUM_W'(mrps_pkg::PRICE_MIN)) begin
      price_nxt = mrps_pkg::PRICE_MIN;
    end else begin
      price_nxt = sum[mrps_pkg::PRICE_W-1:0];
    end
  end

  // Path state doubles as the stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      price_r <= mrps_pkg::START_RST;
      cnt_r   <= '0;
    end else if (load) begin
      price_r <= price_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      begin_r <= begin_nxt;
      done_r  <= done_nxt;
    end
  end

  assign res.price      = price_r;
  assign res.step       = cnt_r;
  assign res.path_begin = begin_r;
  assign res.done       = done_r;

endmodule

[rtl/core/mrps_stats.sv]
// Statistics stage: running max/min with earliest index and threshold
// crossing count; its registers are the result register. Depends on mrps_pkg.
`timescale 1ns / 1ps

module mrps_stats (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  mrps_pkg::step_res_t  step_in,
  input  mrps_pkg::cfg_t       cfg,
  output mrps_pkg::stats_res_t res
);

  mrps_pkg::price_t hi_r, hi_nxt, lo_r, lo_nxt, hi_base, lo_base, price_r;
  mrps_pkg::step_t  hi_idx_r, hi_idx_nxt, lo_idx_r, lo_idx_nxt, step_r;
  mrps_pkg::step_t  cross_r, cross_nxt, cross_base;
  logic             armed_r, armed_nxt, armed_base, done_r;

  // Restart the per-path statistics when the step opened a new path
  always_comb begin
    hi_base    = step_in.path_begin ? cfg.start : hi_r;
    lo_base    = step_in.path_begin ? cfg.start : lo_r;
    hi_idx_nxt = step_in.path_begin ? '0 : hi_idx_r;
    lo_idx_nxt = step_in.path_begin ? '0 : lo_idx_r;
    armed_base = step_in.path_begin ? 1'b0 : armed_r;
    cross_base = step_in.path_begin ? '0 : cross_r;

    // Strict improvement keeps the earliest index
    hi_nxt = hi_base;
    lo_nxt = lo_base;
    if (step_in.price > hi_base) begin
      hi_nxt     = step_in.price;
      hi_idx_nxt = step_in.step;
    end
    if (step_in.price < lo_base) begin
      lo_nxt     = step_in.price;
      lo_idx_nxt = step_in.step;
    end

    // Arm at the upper level; count and disarm at the lower level
    armed_nxt = armed_base;
    cross_nxt = cross_base;
    priority if (step_in.price >= cfg.upper) begin
      armed_nxt = 1'b1;
    end else if ((step_in.price <= cfg.lower) && armed_base) begin
      armed_nxt = 1'b0;
      if (cross_base != '1) begin
        cross_nxt = cross_base + mrps_pkg::step_t'(1);
      end
    end
  end

  // Statistics state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_r     <= mrps_pkg::START_RST;
      lo_r     <= mrps_pkg::START_RST;
      hi_idx_r <= '0;
      lo_idx_r <= '0;
      armed_r  <= 1'b0;
      cross_r  <= '0;
    end else if (load) begin
      hi_r     <= hi_nxt;
      lo_r     <= lo_nxt;
      hi_idx_r <= hi_idx_nxt;
      lo_idx_r <= lo_idx_nxt;
      armed_r  <= armed_nxt;
      cross_r  <= cross_nxt;
    end
  end

  // Pass-through payload
  always_ff @(posedge clk) begin
    if (load) begin
      price_r <= step_in.price;
      step_r  <= step_in.step;
      done_r  <= step_in.done;
    end
  end

  assign res.price     = price_r;
  assign res.step      = step_r;
  assign res.max_price = hi_r;
  assign res.max_step  = hi_idx_r;
  assign res.min_price = lo_r;
  assign res.min_step  = lo_idx_r;
  assign res.crossings = cross_r;
  assign res.done      = done_r;

endmodule

[rtl/core/mrps_checker.sv]
// Port-level checks on the result channel of the path generator, bound
// to the top level. Depends on mrps_pkg and the top level.
`timescale 1ns / 1ps

module mrps_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input mrps_pkg::price_t price,
  input mrps_pkg::step_t  step_number,
  input mrps_pkg::price_t max_price,
  input mrps_pkg::step_t  max_step,
  input mrps_pkg::price_t min_price,
  input mrps_pkg::step_t  min_step
);

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(price) && $stable(step_number))
    else $error("result changed while stalled");

  // Extremes bracket the current price
  a_extremes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (max_price >= price) && (min_price <= price))
    else $error("price outside running max/min");

  // Step indices are in range of the current step
  a_indices: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (step_number != '0) && (max_step <= step_number)
                  && (min_step <= step_number))
    else $error("bad step index");

  // First step of a path: either an extreme moved to it or both still sit at the start
  a_first_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (step_number == mrps_pkg::step_t'(1)) |->
      (max_step == step_number) || (min_step == step_number) || (max_price == min_price))
    else $error("inconsistent statistics on first step");

endmodule

bind mean_reverting_path_with_stats_core mrps_checker u_mrps_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .price       (out_ch.price),
  .step_number (out_ch.step_number),
  .max_price   (out_ch.max_price),
  .max_step    (out_ch.max_step),
  .min_price   (out_ch.min_price),
  .min_step    (out_ch.min_step)
);

[bench/mrps_path_audit.sv]
// Monitor and self-check for the mean-reverting path block: follows register writes,
// predicts each step's price and path statistics, compares result transactions.
// Depends on mrps_pkg and mrps_if.
`timescale 1ns / 1ps

module mrps_path_audit (
  input  logic                            clk,
  input  logic                            rst_n,
  mrps_in_if                              in_mon,
  mrps_out_if                             out_mon,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [mrps_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mrps_pkg::CFG_DATA_W-1:0] pwdata,
  output int unsigned                     outstanding,
  output int unsigned                     fail_count
);
  import mrps_pkg::*;

  // Wide enough for (mean - price) * gain without overflow
  typedef logic signed [79:0] wide_t;
  localparam int FIELD_W = (PRICE_W > STEP_W) ? PRICE_W : STEP_W;

  cfg_t       regs;
  price_t     price_now, peak, trough;
  step_t      steps_taken, peak_at, trough_at, cross_cnt;
  logic       armed;
  stats_res_t path_q[$];

  // Reload path state from the start price
  function automatic void begin_path();
    price_now   = regs.start;
    steps_taken = '0;
    peak        = regs.start;
    trough      = regs.start;
    peak_at     = '0;
    trough_at   = '0;
    armed       = 1'b0;
    cross_cnt   = '0;
  endfunction

  // One Euler step of the mean-reverting price plus statistics update
  function automatic stats_res_t advance_path(input logic up, input logic restart);
    stats_res_t r;
    step_t      len;
    wide_t      gap, pull, nxt, lim_hi, lim_lo;
    len = (regs.length == '0) ? step_t'(1) : regs.length;
    if (restart || steps_taken >= len)
      begin_path();
    steps_taken = steps_taken + step_t'(1);

    // reversion term, floor of gap * gain / 2^32
    gap  = wide_t'($signed(regs.mean)) - wide_t'($signed(price_now));
    pull = (gap * $signed({{(80-GAIN_W){1'b0}}, regs.gain})) >>> 32;
    nxt  = wide_t'($signed(price_now)) + pull;
    if (up)
      nxt = nxt + wide_t'({1'b0, regs.noise});
    else
      nxt = nxt - wide_t'({1'b0, regs.noise});

    // saturate to the price range
    lim_hi = wide_t'(PRICE_MAX);
    lim_lo = wide_t'(PRICE_MIN);
    if (nxt > lim_hi)
      nxt = lim_hi;
    else if (nxt < lim_lo)
      nxt = lim_lo;
    price_now = price_t'(nxt[PRICE_W-1:0]);

    // strict improvement only, so ties keep the earliest index
    if ($signed(price_now) > $signed(peak)) begin
      peak    = price_now;
      peak_at = steps_taken;
    end
    if ($signed(price_now) < $signed(trough)) begin
      trough    = price_now;
      trough_at = steps_taken;
    end

    // arming wins when the levels overlap
    if ($signed(price_now) >= $signed(regs.upper)) begin
      armed = 1'b1;
    end else if ($signed(price_now) <= $signed(regs.lower) && armed) begin
      if (cross_cnt != '1)
        cross_cnt = cross_cnt + step_t'(1);
      armed = 1'b0;
    end

    r.price     = price_now;
    r.step      = steps_taken;
    r.max_price = peak;
    r.max_step  = peak_at;
    r.min_price = trough;
    r.min_step  = trough_at;
    r.crossings = cross_cnt;
    r.done      = (steps_taken >= len);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
                             input logic [FIELD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Register writes, result checks and step predictions, all on the clock edge
  always @(posedge clk) begin
    stats_res_t want;
    reg_idx_t   idx;
    if (!rst_n) begin
      regs = '{gain: GAIN_RST, mean: MEAN_RST, noise: NOISE_RST, start: START_RST,
               upper: UPPER_RST, lower: LOWER_RST, length: LENGTH_RST};
      begin_path();
      path_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        idx = reg_idx_t'(paddr[CFG_ADDR_W-1:CFG_ADDR_LSB]);
        case (idx)
          REG_GAIN:   regs.gain   = pwdata[GAIN_W-1:0];
          REG_MEAN:   regs.mean   = price_t'(pwdata[PRICE_W-1:0]);
          REG_NOISE:  regs.noise  = pwdata[NOISE_W-1:0];
          REG_START:  regs.start  = price_t'(pwdata[PRICE_W-1:0]);
          REG_UPPER:  regs.upper  = price_t'(pwdata[PRICE_W-1:0]);
          REG_LOWER:  regs.lower  = price_t'(pwdata[PRICE_W-1:0]);
          REG_LENGTH: regs.length = pwdata[STEP_W-1:0];
          default: ;
        endcase
      end

      if (out_mon.valid && out_mon.ready) begin
        if (path_q.size() == 0) begin
          $error("result transaction with no step pending: price %0h", out_mon.price);
          fail_count++;
        end else begin
          want = path_q.pop_front();
          check_field("price", FIELD_W'($unsigned(want.price)),
                      FIELD_W'($unsigned(out_mon.price)));
          check_field("step_number", FIELD_W'(want.step), FIELD_W'(out_mon.step_number));
          check_field("max_price", FIELD_W'($unsigned(want.max_price)),
                      FIELD_W'($unsigned(out_mon.max_price)));
          check_field("max_step", FIELD_W'(want.max_step), FIELD_W'(out_mon.max_step));
          check_field("min_price", FIELD_W'($unsigned(want.min_price)),
                      FIELD_W'($unsigned(out_mon.min_price)));
          check_field("min_step", FIELD_W'(want.min_step), FIELD_W'(out_mon.min_step));
          check_field("crossing_count", FIELD_W'(want.crossings),
                      FIELD_W'(out_mon.crossing_count));
          check_field("path_done", FIELD_W'(want.done), FIELD_W'(out_mon.path_done));
        end
      end

      if (in_mon.valid && in_mon.ready)
        path_q.push_back(advance_path(in_mon.up_step, in_mon.restart_path));
    end
    outstanding <= path_q.size();
  end

endmodule

[bench/mean_reverting_path_with_stats_core_test.sv]
// Top of the bench for the mean-reverting path block: clock, reset, register
// setup, step stimulus and result back-pressure. Depends on mrps_pkg, mrps_if,
// mrps_path_audit and the block itself.
`timescale 1ns / 1ps

module mean_reverting_path_with_stats_core_test;
  import mrps_pkg::*;

  localparam int RESET_CYCLES    = 11;
  localparam int RANDOM_PHASES   = 9;
  localparam int STEPS_PER_PHASE = 150;
  localparam int SQUEEZE_CYCLES  = 400;
  localparam int TAIL_CYCLES     = 10;
  localparam int CYCLE_LIMIT     = 500000;

  localparam noise_t NOISE_TOP = '1;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel, penable, pwrite, pready;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata, prdata;
  logic                  calm, squeeze_req;
  int unsigned           outstanding, fail_count, cycles;

  mrps_in_if  in_ch();
  mrps_out_if out_ch();

  always #2 clk = ~clk;

  mean_reverting_path_with_stats_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mrps_path_audit audit (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("mean_reverting_path_with_stats_core: mismatch");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off on request, none when calm
  initial begin : result_sink
    bit squeezed;
    squeezed = 1'b0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  // APB write: setup phase, access phase, then back to idle
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, {CFG_ADDR_LSB{1'b0}}};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input cfg_t c);
    write_reg(REG_GAIN,   CFG_DATA_W'(c.gain));
    write_reg(REG_MEAN,   CFG_DATA_W'(c.mean));
    write_reg(REG_NOISE,  CFG_DATA_W'(c.noise));
    write_reg(REG_START,  CFG_DATA_W'(c.start));
    write_reg(REG_UPPER,  CFG_DATA_W'(c.upper));
    write_reg(REG_LOWER,  CFG_DATA_W'(c.lower));
    write_reg(REG_LENGTH, CFG_DATA_W'(c.length));
  endtask

  // One step transaction, with an optional random gap before it
  task automatic send_step(input logic up, input logic restart);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.up_step      <= up;
    in_ch.restart_path <= restart;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Mostly a band around a mean so crossings happen; wild picks hit the extremes
  function automatic cfg_t random_cfg(input bit wild);
    cfg_t        c;
    logic [31:0] band;
    c.mean   = price_t'($urandom_range(60, 140) << FRAC_W);
    c.noise  = noise_t'($urandom_range(1 << 10, 1 << 17));
    band     = c.noise * $urandom_range(1, 6);
    c.upper  = c.mean + price_t'(band);
    c.lower  = c.mean - price_t'(band);
    c.start  = c.mean + price_t'($urandom_range(0, 2 * band) - band);
    c.gain   = gain_t'($urandom_range(0, 1 << 28));
    c.length = ($urandom_range(0, 7) == 0) ? step_t'($urandom_range(41, 1048575))
                                           : step_t'($urandom_range(1, 40));
    if (wild) begin
      case ($urandom_range(0, 2))
        0:       c.gain = '0;
        1:       c.gain = '1;
        default: c.gain = gain_t'($urandom());
      endcase
      case ($urandom_range(0, 2))
        0:       c.mean = PRICE_MIN;
        1:       c.mean = PRICE_MAX;
        default: c.mean = price_t'($urandom());
      endcase
      case ($urandom_range(0, 2))
        0:       c.noise = '0;
        1:       c.noise = NOISE_TOP;
        default: c.noise = noise_t'($urandom());
      endcase
      case ($urandom_range(0, 2))
        0:       c.start = PRICE_MIN;
        1:       c.start = PRICE_MAX;
        default: c.start = price_t'($urandom());
      endcase
      if ($urandom_range(0, 1) == 0) begin
        c.upper = price_t'($urandom());
        c.lower = price_t'($urandom());
      end
      case ($urandom_range(0, 2))
        0:       c.length = '0;
        1:       c.length = '1;
        default: c.length = step_t'($urandom_range(1, 40));
      endcase
    end
    return c;
  endfunction

  initial begin : stimulus
    cfg_t c;
    rst_n              <= 1'b0;
    calm               <= 1'b0;
    squeeze_req        <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.up_step      <= 1'b0;
    in_ch.restart_path <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, both directions, explicit restart
    send_step(1'b1, 1'b0);
    send_step(1'b0, 1'b0);
    send_step(1'b1, 1'b1);
    settle();

    // clamp at the top, ties at the maximum, path end by length
    c = '{gain: gain_t'(0), mean: price_t'(0), noise: NOISE_TOP, start: PRICE_MAX - 5,
          upper: PRICE_MAX, lower: PRICE_MIN, length: step_t'(4)};
    write_all(c);
    send_step(1'b1, 1'b0);
    send_step(1'b1, 1'b0);
    send_step(1'b0, 1'b0);
    send_step(1'b0, 1'b0);
    send_step(1'b1, 1'b0);
    settle();

    // clamp at the bottom with full gain toward the lowest mean
    c = '{gain: '1, mean: PRICE_MIN, noise: NOISE_TOP, start: PRICE_MIN + 3,
          upper: PRICE_MAX, lower: PRICE_MIN, length: step_t'(3)};
    write_all(c);
    send_step(1'b0, 1'b0);
    send_step(1'b0, 1'b0);
    send_step(1'b1, 1'b1);
    send_step(1'b0, 1'b0);
    settle();

    // upper and lower level equal: arming is tested first
    c = '{gain: gain_t'(0), mean: price_t'(0), noise: noise_t'(1 << FRAC_W),
          start: price_t'(0), upper: price_t'(0), lower: price_t'(0), length: step_t'(10)};
    write_all(c);
    send_step(1'b1, 1'b0);
    send_step(1'b0, 1'b0);
    send_step(1'b0, 1'b0);
    send_step(1'b1, 1'b0);
    send_step(1'b0, 1'b0);
    settle();

    // zero path length behaves as one step per path
    write_reg(REG_LENGTH, '0);
    send_step(1'b1, 1'b0);
    send_step(1'b0, 1'b0);
    settle();

    // half gain on small negative gaps: reversion rounds toward minus infinity
    c = '{gain: gain_t'(32'h8000_0000), mean: price_t'(0), noise: noise_t'(0),
          start: price_t'(3), upper: PRICE_MAX, lower: PRICE_MIN, length: step_t'(6)};
    write_all(c);
    send_step(1'b0, 1'b1);
    send_step(1'b0, 1'b0);
    send_step(1'b1, 1'b0);
    send_step(1'b0, 1'b0);
    settle();

    // random phases; path state carries over between them
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_all(random_cfg(p % 3 == 1));
      if (p == 2)
        squeeze_req <= 1'b1;
      if (p == RANDOM_PHASES - 2)
        calm <= 1'b1;
      for (int i = 0; i < STEPS_PER_PHASE; i++)
        send_step(1'($urandom_range(0, 1)), $urandom_range(0, 39) == 0);
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("mean_reverting_path_with_stats_core: match");
    else
      $display("mean_reverting_path_with_stats_core: mismatch");
    $finish;
  end

endmodule
